/* rtl/radix_digit_converter_assert.svh */
// Assertion macros used by the radix digit converter checker
`ifndef RADIX_DIGIT_CONVERTER_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset
`define RDC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset
`define RDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rdc_pkg.sv */
// Shared constants and helpers for the radix digit converter
package rdc_pkg;

    // Field widths
    localparam int RADIX_W  = 6;
    localparam int CHAR_W   = 7;
    localparam int COUNT_W  = 7;
    localparam int DATA_W   = 32;

    // Quotient bits retired per divider cycle
    localparam int STEP_BITS = 8;

    // Radix limits and reset value
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd16;

    // Register index codes
    localparam logic REG_RADIX = 1'b0;

    // ASCII digit constants
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 7'h39;
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;
    localparam logic [CHAR_W-1:0] ASCII_Z    = 7'h5A;
    localparam int DEC_DIGITS = 10;

    // Map a digit value to its ASCII character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        if (d < RADIX_W'(DEC_DIGITS)) begin
            return ASCII_ZERO + CHAR_W'(d);
        end
        return ASCII_A + CHAR_W'(d - RADIX_W'(DEC_DIGITS));
    endfunction

endpackage

/* rtl/rdc_ram.sv */
// Generic single-write, single-read RAM with registered read data
module rdc_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/radix_digit_converter.sv */
// Each digit comes from the shared 8-bit-per-cycle restoring divider (ST_DIV) and is written
// to the digit memory (ST_DIGIT); once the quotient is zero the digits are read back (ST_READ,
// ST_LOAD) and presented most significant first, each held in ST_HOLD until it is taken.
// One item at a time: s_ready is high only while idle.
// Reset (aresetn low at a clock edge): radix returns to 16, control goes idle, no result pending;
// the digit memory is not cleared.
module radix_digit_converter
    import rdc_pkg::*;
#(
    parameter int MAX_DIGITS = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    // input channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [63:0]         s_value,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CHAR_W-1:0]   m_digit_char,
    output logic [COUNT_W-1:0]  m_digit_count,
    output logic                m_last_digit
);

    localparam int AW    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int STEPS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int QW    = STEPS * STEP_BITS;
    localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_DIGIT = 6'b000100,
        ST_READ  = 6'b001000,
        ST_LOAD  = 6'b010000,
        ST_HOLD  = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [RADIX_W-1:0]   radix_reg, radix_next;
    logic [QW-1:0]        quo_reg, quo_next;
    logic [RADIX_W-1:0]   rem_reg, rem_next;
    logic [SW-1:0]        step_reg, step_next;
    logic [AW-1:0]        wptr_reg, wptr_next;
    logic [AW-1:0]        rptr_reg, rptr_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [COUNT_W-1:0]   left_reg, left_next;
    logic                 m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 last_reg, last_next;

    logic                 cfg_wr;
    logic [RADIX_W-1:0]   wr_val;
    logic [RADIX_W:0]     trial;
    logic [RADIX_W-1:0]   rem_step;
    logic [STEP_BITS-1:0] top_bits;
    logic [STEP_BITS-1:0] qbits;
    logic [QW-1:0]        quo_shift;
    logic [COUNT_W-1:0]   cnt_inc;
    logic                 ram_we;
    logic                 ram_re;
    logic [RADIX_W-1:0]   ram_rdata;

    // Configuration write and readback
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_RADIX);
    assign wr_val = pwdata[RADIX_W-1:0];
    assign prdata = (paddr[2] == REG_RADIX) ? DATA_W'(radix_reg) : '0;

    // Saturate written radix into the legal range
    always_comb begin
        radix_next = radix_reg;
        if (cfg_wr) begin
            if (wr_val < RADIX_MIN) begin
                radix_next = RADIX_MIN;
            end else if (wr_val > RADIX_MAX) begin
                radix_next = RADIX_MAX;
            end else begin
                radix_next = wr_val;
            end
        end
    end

    // Shared divider: retire STEP_BITS quotient bits per cycle, restoring style
    assign top_bits = quo_reg[QW-1 -: STEP_BITS];

    always_comb begin
        rem_step = rem_reg;
        trial    = '0;
        qbits    = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial = {rem_step, top_bits[STEP_BITS-1-i]};
            if (trial >= {1'b0, radix_reg}) begin
                trial = trial - {1'b0, radix_reg};
                qbits[STEP_BITS-1-i] = 1'b1;
            end
            rem_step = trial[RADIX_W-1:0];
        end
    end

    if (STEPS > 1) begin : g_shift
        assign quo_shift = {quo_reg[QW-STEP_BITS-1:0], qbits};
    end else begin : g_single
        assign quo_shift = qbits;
    end

    // Saturating digit count
    assign cnt_inc = (cnt_reg == COUNT_W'(MAX_DIGITS)) ? cnt_reg : cnt_reg + COUNT_W'(1);

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        wptr_next    = wptr_reg;
        rptr_next    = rptr_reg;
        cnt_next     = cnt_reg;
        left_next    = left_reg;
        m_valid_next = m_valid_reg;
        char_next    = char_reg;
        count_next   = count_reg;
        last_next    = last_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // take a new value, start the first division
                if (s_valid) begin
                    quo_next   = QW'(s_value[VALUE_BITS-1:0]);
                    rem_next   = '0;
                    step_next  = '0;
                    wptr_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                quo_next  = quo_shift;
                rem_next  = rem_step;
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(STEPS - 1)) begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                // store remainder in the ring, the oldest drops when full
                ram_we    = 1'b1;
                wptr_next = (wptr_reg == AW'(MAX_DIGITS - 1)) ? '0 : wptr_reg + AW'(1);
                cnt_next  = cnt_inc;
                rem_next  = '0;
                step_next = '0;
                if (quo_reg == '0) begin
                    rptr_next  = wptr_reg;
                    left_next  = cnt_inc;
                    state_next = ST_READ;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_READ: begin
                ram_re     = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                char_next    = digit_char(ram_rdata);
                count_next   = cnt_reg;
                last_next    = (left_reg == COUNT_W'(1));
                m_valid_next = 1'b1;
                state_next   = ST_HOLD;
            end
            ST_HOLD: begin
                // wait for the transfer, then walk toward less significant digits
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (left_reg == COUNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        left_next  = left_reg - COUNT_W'(1);
                        rptr_next  = (rptr_reg == '0) ? AW'(MAX_DIGITS - 1)
                                                      : rptr_reg - AW'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            radix_reg   <= RADIX_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            radix_reg   <= radix_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        step_reg  <= step_next;
        wptr_reg  <= wptr_next;
        rptr_reg  <= rptr_next;
        cnt_reg   <= cnt_next;
        left_reg  <= left_next;
        char_reg  <= char_next;
        count_reg <= count_next;
        last_reg  <= last_next;
    end

    // Digit memory
    rdc_ram #(
        .WIDTH (RADIX_W),
        .DEPTH (MAX_DIGITS)
    ) u_digit_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata (rem_reg),
        .re    (ram_re),
        .raddr (rptr_reg),
        .rdata (ram_rdata)
    );

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_digit_char  = char_reg;
    assign m_digit_count = count_reg;
    assign m_last_digit  = last_reg;

endmodule

/* rtl/rdc_checker.sv */
// Port-level assertion checker for the radix digit converter, with its bind
`include "radix_digit_converter_assert.svh"

module rdc_checker
    import rdc_pkg::*;
#(
    parameter int MAX_DIGITS = 64
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [CHAR_W-1:0]   m_digit_char,
    input logic [COUNT_W-1:0]  m_digit_count,
    input logic                m_last_digit
);

    logic [CHAR_W+COUNT_W:0] result_bus;
    logic                    stalled;
    logic                    in_xfer;
    logic                    out_xfer;
    logic                    char_legal;
    logic                    count_legal;

    // Handshake and payload views used by the checks
    assign result_bus  = {m_digit_char, m_digit_count, m_last_digit};
    assign stalled     = m_valid && !m_ready;
    assign in_xfer     = s_valid && s_ready;
    assign out_xfer    = m_valid && m_ready;
    assign char_legal  = (m_digit_char >= ASCII_ZERO && m_digit_char <= ASCII_NINE) ||
                         (m_digit_char >= ASCII_A && m_digit_char <= ASCII_Z);
    assign count_legal = (m_digit_count != '0) && (m_digit_count <= COUNT_W'(MAX_DIGITS));

    // Hold a stalled result
    `RDC_ASSERT_NEXT(a_hold_stall, stalled, m_valid && $stable(result_bus), "stall not held")

    // Take no new value while a digit is pending
    `RDC_ASSERT_IMPL(a_no_take_while_out, m_valid, !s_ready, "input ready while result pending")

    // Go busy right after a transfer in
    `RDC_ASSERT_NEXT(a_busy_after_take, in_xfer, !s_ready && !m_valid, "not busy after transfer")

    // Digits are legal ASCII and the count is in range
    `RDC_ASSERT_IMPL(a_payload_legal, m_valid, char_legal && count_legal, "illegal digit or count")

    // Drop valid after the final digit is taken
    `RDC_ASSERT_NEXT(a_end_of_run, out_xfer && m_last_digit, !m_valid, "result after last digit")

endmodule

bind radix_digit_converter rdc_checker #(.MAX_DIGITS(MAX_DIGITS)) u_rdc_checker (.*);

/* dv/radix_digit_converter_tb.sv */
// Self-checking testbench for the radix digit converter: APB radix setup, stream in, digits out
module radix_digit_converter_tb;
    import rdc_pkg::*;

    localparam int          DIGIT_LIMIT  = 64;
    localparam int          VALUE_WIDTH  = 64;
    localparam logic [63:0] VALUE_MASK   = {64{1'b1}} >> (64 - VALUE_WIDTH);
    localparam logic [2:0]  ADDR_RADIX   = {REG_RADIX, 2'b00};
    localparam logic [2:0]  ADDR_UNMAPPED = 3'd4;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          HOLD_CYCLES  = 500;
    localparam int          RANDOM_PHASES = 12;
    localparam int          PHASE_ITEMS  = 30;
    // worst case: every item 64 digits, each digit behind the longest receiver stall, with margin
    localparam int          CYCLE_LIMIT  = 5_000_000;

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [COUNT_W-1:0] count;
        logic               last;
    } digit_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [2:0]          paddr    = '0;
    logic [DATA_W-1:0]   pwdata   = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid  = 1'b0;
    logic                s_ready;
    logic [63:0]         s_value  = '0;
    logic                m_valid;
    logic                m_ready  = 1'b0;
    logic [CHAR_W-1:0]   m_digit_char;
    logic [COUNT_W-1:0]  m_digit_count;
    logic                m_last_digit;

    logic [63:0]         pending_values[$];
    digit_result_t       expected_digits[$];
    logic [RADIX_W-1:0]  radix_model = RADIX_RESET;
    int                  queued_items = 0;
    int                  accepted_items = 0;
    int                  digit_errors = 0;
    int                  readback_errors = 0;
    int                  send_gap = 0;
    int                  recv_stall = 0;
    int                  cycle_count = 0;
    int                  hold_count = 0;
    logic                hold_armed = 1'b0;
    logic                burst_mode = 1'b0;
    logic                holding;

    radix_digit_converter u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digit_char  (m_digit_char),
        .m_digit_count (m_digit_count),
        .m_last_digit  (m_last_digit)
    );

    always #6 aclk = ~aclk;

    // Saturate a written word into the legal radix range
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [DATA_W-1:0] word);
        logic [RADIX_W-1:0] v;
        v = word[RADIX_W-1:0];
        if (v < RADIX_MIN) begin
            v = RADIX_MIN;
        end else if (v > RADIX_MAX) begin
            v = RADIX_MAX;
        end
        return v;
    endfunction

    // Expand one value into its digits, most significant first, and queue them
    function automatic void predict_digits(input logic [63:0] value,
                                           input logic [RADIX_W-1:0] base);
        logic [63:0]        q;
        logic [RADIX_W-1:0] remainders[$];
        digit_result_t      entry;
        int                 n;
        int                 k;
        q = value & VALUE_MASK;
        do begin
            remainders.push_back(RADIX_W'(q % base));
            q = q / base;
        end while (q != 0);
        // keep only the least significant digits when there are too many
        while (remainders.size() > DIGIT_LIMIT) begin
            void'(remainders.pop_back());
        end
        n = remainders.size();
        for (k = n - 1; k >= 0; k--) begin
            if (remainders[k] < RADIX_W'(DEC_DIGITS)) begin
                entry.ch = ASCII_ZERO + CHAR_W'(remainders[k]);
            end else begin
                entry.ch = ASCII_A + CHAR_W'(remainders[k]) - CHAR_W'(DEC_DIGITS);
            end
            entry.count = COUNT_W'(n);
            entry.last  = (k == 0);
            expected_digits.push_back(entry);
        end
    endfunction

    // Idle length: mostly none, often short, now and then long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       v = 64'($urandom_range(0, 40));
            1, 2, 3: v = v >> $urandom_range(1, 63);
            default: ;
        endcase
        return v;
    endfunction

    task automatic offer_value(input logic [63:0] value);
        pending_values.push_back(value);
        queued_items++;
    endtask

    // Write a register, then read the radix back and compare
    task automatic write_config(input logic [2:0] addr, input logic [DATA_W-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (addr == ADDR_RADIX) begin
            radix_model = clamp_radix(data);
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_RADIX;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== DATA_W'(radix_model)) begin
            readback_errors++;
            $display("%0t radix readback: expected %0d, got %0d", $time, radix_model, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait until every offered value is taken and every digit has come back
    task automatic drain_phase();
        while (accepted_items != queued_items || expected_digits.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Driver: present queued values, hold each one until its transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_value  <= '0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_digits(s_value, radix_model);
                accepted_items++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    s_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_values.size() != 0) begin
                    s_value  <= pending_values.pop_front();
                    s_valid  <= 1'b1;
                    send_gap <= idle_length();
                end else begin
                    s_valid  <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted once armed
    always @(posedge aclk) begin
        if (hold_armed && hold_count != HOLD_CYCLES) begin
            hold_count <= hold_count + 1;
        end
    end
    assign holding = hold_armed && (hold_count != HOLD_CYCLES);

    // Monitor: check each digit transfer against the oldest expectation
    always @(posedge aclk) begin
        digit_result_t seen;
        digit_result_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                seen = '{m_digit_char, m_digit_count, m_last_digit};
                if (expected_digits.size() == 0) begin
                    digit_errors++;
                    $display("%0t unexpected digit: char %h count %0d last %b",
                             $time, seen.ch, seen.count, seen.last);
                end else begin
                    want = expected_digits.pop_front();
                    if (seen !== want) begin
                        digit_errors++;
                        $display("%0t digit mismatch: expected char %h count %0d last %b,",
                                 $time, want.ch, want.count, want.last,
                                 " got char %h count %0d last %b",
                                 seen.ch, seen.count, seen.last);
                    end
                end
            end
            if (holding) begin
                m_ready <= 1'b0;
            end else if (recv_stall != 0) begin
                m_ready    <= 1'b0;
                recv_stall <= recv_stall - 1;
            end else begin
                m_ready    <= 1'b1;
                recv_stall <= idle_length();
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus: directed corners, then random phases with fresh radix settings
    initial begin
        int ph;
        int i;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset radix: zero, single digits, first two-digit value, largest value
        offer_value(64'd0);
        offer_value(64'd1);
        offer_value(64'd15);
        offer_value(64'd16);
        offer_value({64{1'b1}});
        drain_phase();

        // radix below two clamps up to binary: sixty-four digits for the top values
        write_config(ADDR_RADIX, 32'd0);
        offer_value(64'd0);
        offer_value(64'd1);
        offer_value({64{1'b1}});
        offer_value(64'h8000_0000_0000_0000);
        drain_phase();

        // radix above thirty-six clamps down: exercise the 'Z' digit
        write_config(ADDR_RADIX, 32'd37);
        offer_value(64'd35);
        offer_value(64'd36);
        offer_value(64'd1295);
        offer_value({64{1'b1}});
        drain_phase();

        // junk in the upper data bits is dropped, decimal remains
        write_config(ADDR_RADIX, 32'hFFFF_FFCA);
        offer_value(64'd9);
        offer_value(64'd10);
        offer_value(64'd10000000000000000000);
        offer_value({64{1'b1}});
        drain_phase();

        // all-ones field clamps to thirty-six; a write to an unmapped address changes nothing
        write_config(ADDR_RADIX, 32'd63);
        write_config(ADDR_UNMAPPED, 32'd5);
        offer_value(64'hDEAD_BEEF_0123_4567);
        drain_phase();

        write_config(ADDR_RADIX, 32'd1);
        offer_value(64'hAAAA_AAAA_AAAA_AAAA);
        drain_phase();

        // random phases
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            if ($urandom_range(0, 7) == 0) begin
                write_config(ADDR_UNMAPPED, $urandom);
            end else begin
                write_config(ADDR_RADIX, $urandom);
            end
            if (ph == 2) begin
                burst_mode <= 1'b0;
                hold_armed <= 1'b1;
            end else begin
                burst_mode <= ($urandom_range(0, 3) == 0);
            end
            for (i = 0; i < PHASE_ITEMS; i++) begin
                offer_value(random_value());
            end
            drain_phase();
        end

        if (digit_errors + readback_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
